### hw/rtl/periodic_timer_epoch_adjust_defines.svh
// Assertion macros shared by the timer epoch adjust RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef PERIODIC_TIMER_EPOCH_ADJUST_DEFINES_SVH
`define PERIODIC_TIMER_EPOCH_ADJUST_DEFINES_SVH
`ifndef SYNTH
// check a property every clock edge outside reset
`define PTEADJ_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("pteadj check failed");
// check that an antecedent implies a consequent in the next cycle
`define PTEADJ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pteadj next-cycle check failed");
`else
`define PTEADJ_ASSERT(lbl, clk, rst_n, prop)
`define PTEADJ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### hw/rtl/pteadj_pkg.sv
// Types and constants for the timer epoch adjust block.
// Depends on nothing; used by every module of the block.
package pteadj_pkg;

	// adjust case codes
	localparam logic [1:0] CASE_SHIFT  = 2'd0;
	localparam logic [1:0] CASE_SKIP   = 2'd1;
	localparam logic [1:0] CASE_PULL   = 2'd2;
	localparam logic [1:0] CASE_ZEROPD = 2'd3;

	typedef struct packed {
		logic [63:0] expiry_date;
		logic [63:0] expected_date;
		logic [62:0] period_ticks;
		logic        is_periodic;
		logic        has_fired;
		logic signed [63:0] shift_ticks;
		logic [63:0] time_now;
	} req_t;

	typedef struct packed {
		logic [63:0] new_expiry;
		logic [63:0] new_expected;
		logic [1:0]  adjust_case;
	} rsp_t;

	// control that travels alongside each item through the cell row
	typedef struct packed {
		logic       valid;
		logic [1:0] kind;
	} ctrl_t;

endpackage

### hw/rtl/pteadj_front.sv
// Front end: epoch shift, lag/lead compare and case decision, two stages.
// Depends on pteadj_pkg.
module pteadj_front #(
	parameter int W = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  pteadj_pkg::req_t  req,
	output pteadj_pkg::ctrl_t ctrl_o,
	output logic [W-1:0]      dividend_o,
	output logic [W-1:0]      period_o,
	output logic [W-1:0]      exp_base_o,
	output logic [W-1:0]      expd_base_o
);

	logic [63:0]  period_full;
	logic [W-1:0] shift_w, expiry_in_w, expected_in_w, now_w, period_w;
	logic         valid_s1, periodic_s1, fired_s1, neg_s1;
	logic [W-1:0] expiry_s1, expected_s1, period_s1, now_s1;
	logic [W-1:0] diff, lag, lead, neg_diff;
	logic [1:0]   kind;
	logic [W-1:0] dividend, exp_base, expd_base;

	// reduce inputs to the date width
	assign shift_w       = req.shift_ticks[W-1:0];
	assign expiry_in_w   = req.expiry_date[W-1:0];
	assign expected_in_w = req.expected_date[W-1:0];
	assign now_w         = req.time_now[W-1:0];
	assign period_full   = {1'b0, req.period_ticks};
	assign period_w      = period_full[W-1:0];

	// stage 1: apply the epoch shift
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		expiry_s1   <= expiry_in_w - shift_w;
		expected_s1 <= req.is_periodic ? (expected_in_w - shift_w) : expected_in_w;
		period_s1   <= period_w;
		now_s1      <= now_w;
		periodic_s1 <= req.is_periodic;
		fired_s1    <= req.has_fired;
		neg_s1      <= shift_w[W-1];
	end

	// stage 2: measure lag against now and pick the case
	assign diff     = now_s1 - expiry_s1;
	assign lag      = diff - period_s1;
	assign lead     = diff + period_s1;
	assign neg_diff = '0 - diff;

	always_comb begin
		kind      = pteadj_pkg::CASE_SHIFT;
		dividend  = '0;
		exp_base  = expiry_s1;
		expd_base = expected_s1;
		if (periodic_s1) begin
			if (period_s1 == '0) begin
				kind = pteadj_pkg::CASE_ZEROPD;
			end else if (!lag[W-1]) begin
				kind     = pteadj_pkg::CASE_SKIP;
				dividend = diff;
				exp_base = now_s1;
			end else if (neg_s1 && fired_s1 && (lead == '0 || lead[W-1])) begin
				kind      = pteadj_pkg::CASE_PULL;
				dividend  = neg_diff;
				exp_base  = now_s1;
				expd_base = expected_s1 + diff;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_o <= '0;
		end else begin
			ctrl_o.valid <= valid_s1;
			ctrl_o.kind  <= kind;
		end
	end

	always_ff @(posedge clk) begin
		dividend_o  <= dividend;
		period_o    <= period_s1;
		exp_base_o  <= exp_base;
		expd_base_o <= expd_base;
	end

endmodule

### hw/rtl/pteadj_cell.sv
// One remainder cell: shifts in one dividend bit and subtracts the period where it fits.
// Depends on pteadj_pkg and the assertion macro header.
`include "periodic_timer_epoch_adjust_defines.svh"
module pteadj_cell #(
	parameter int W = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  pteadj_pkg::ctrl_t ctrl_i,
	input  logic [W-1:0]      rem_i,
	input  logic [W-1:0]      dividend_i,
	input  logic [W-1:0]      period_i,
	input  logic [W-1:0]      exp_base_i,
	input  logic [W-1:0]      expd_base_i,
	output pteadj_pkg::ctrl_t ctrl_o,
	output logic [W-1:0]      rem_o,
	output logic [W-1:0]      dividend_o,
	output logic [W-1:0]      period_o,
	output logic [W-1:0]      exp_base_o,
	output logic [W-1:0]      expd_base_o
);

	logic [W:0] trial, diffp;
	logic [W-1:0] rem_nxt;

	// restoring step on the next dividend bit
	assign trial   = {rem_i, dividend_i[W-1]};
	assign diffp   = trial - {1'b0, period_i};
	assign rem_nxt = (trial >= {1'b0, period_i}) ? diffp[W-1:0] : trial[W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_o <= '0;
		end else begin
			ctrl_o <= ctrl_i;
		end
	end

	// hand the item to the next cell
	always_ff @(posedge clk) begin
		rem_o       <= rem_nxt;
		dividend_o  <= {dividend_i[W-2:0], 1'b0};
		period_o    <= period_i;
		exp_base_o  <= exp_base_i;
		expd_base_o <= expd_base_i;
	end

	`PTEADJ_ASSERT(a_rem_bound, clk, arst_n, !ctrl_o.valid || period_o == '0 || rem_o < period_o)
	`PTEADJ_ASSERT_NEXT(a_valid_adv, clk, arst_n, ctrl_i.valid, ctrl_o.valid)
	`PTEADJ_ASSERT_NEXT(a_kind_adv, clk, arst_n, ctrl_i.valid, ctrl_o.kind == $past(ctrl_i.kind))

endmodule

### hw/rtl/periodic_timer_epoch_adjust.sv
// Top level of the timer epoch adjust block: front end, remainder cell row,
// output stage. Depends on pteadj_pkg, pteadj_front and pteadj_cell.
//
// Usage: drive one timer item on req and pulse start; busy is always low,
// so an item is taken every cycle that start is high. Each item yields one
// result on rsp, marked by done for exactly one cycle.
// Path: two front stages, one cell per remainder bit, then one output
// register that drives done and rsp.
// Throughput: one item per cycle; the cell row holds up to TIME_WIDTH items.
// The figure is set by the row of TIME_WIDTH restoring remainder cells.
// Reset clears all valid flags at once; items in flight are dropped and
// no done pulse follows until a new item is started.
// The receiver cannot stall: every result must be taken in its done cycle.
// Dates are reduced to TIME_WIDTH bits and wrap modulo 2^TIME_WIDTH.
module periodic_timer_epoch_adjust #(
	parameter int TIME_WIDTH = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  pteadj_pkg::req_t req,
	output logic             done,
	output pteadj_pkg::rsp_t rsp
);

	localparam int W = TIME_WIDTH;

	pteadj_pkg::ctrl_t ctrl_c [W+1];
	logic [W-1:0] rem_c [W+1];
	logic [W-1:0] div_c [W+1];
	logic [W-1:0] per_c [W+1];
	logic [W-1:0] eb_c  [W+1];
	logic [W-1:0] xb_c  [W+1];
	logic [W-1:0] expiry_fin, expected_fin;

	assign busy     = 1'b0;
	assign rem_c[0] = '0;

	pteadj_front #(.W(W)) u_front (
		.clk(clk), .arst_n(arst_n), .take(start), .req(req),
		.ctrl_o(ctrl_c[0]), .dividend_o(div_c[0]), .period_o(per_c[0]),
		.exp_base_o(eb_c[0]), .expd_base_o(xb_c[0])
	);

	// row of remainder cells, one bit per cell
	for (genvar i = 0; i < W; i++) begin : g_cell
		pteadj_cell #(.W(W)) u_cell (
			.clk(clk), .arst_n(arst_n),
			.ctrl_i(ctrl_c[i]), .rem_i(rem_c[i]), .dividend_i(div_c[i]),
			.period_i(per_c[i]), .exp_base_i(eb_c[i]), .expd_base_i(xb_c[i]),
			.ctrl_o(ctrl_c[i+1]), .rem_o(rem_c[i+1]), .dividend_o(div_c[i+1]),
			.period_o(per_c[i+1]), .exp_base_o(eb_c[i+1]), .expd_base_o(xb_c[i+1])
		);
	end

	// apply the whole-period step
	always_comb begin
		expiry_fin   = eb_c[W];
		expected_fin = xb_c[W];
		case (ctrl_c[W].kind)
			pteadj_pkg::CASE_SKIP: begin
				expiry_fin = eb_c[W] - rem_c[W];
			end
			pteadj_pkg::CASE_PULL: begin
				expiry_fin   = eb_c[W] + rem_c[W];
				expected_fin = xb_c[W] + rem_c[W];
			end
			default: begin
				expiry_fin   = eb_c[W];
				expected_fin = xb_c[W];
			end
		endcase
	end

	// hold the result for its done cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= ctrl_c[W].valid;
		end
	end

	always_ff @(posedge clk) begin
		rsp.new_expiry   <= 64'(expiry_fin);
		rsp.new_expected <= 64'(expected_fin);
		rsp.adjust_case  <= ctrl_c[W].kind;
	end

endmodule

### tb/sv/periodic_timer_epoch_adjust_checker.sv
// Checker for the timer epoch adjust block: predicts each result from the
// accepted timer item and compares it with the done-marked output.
// Depends on pteadj_pkg.
`timescale 1ns / 100ps

module periodic_timer_epoch_adjust_checker (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             busy,
	input  pteadj_pkg::req_t req,
	input  logic             done,
	input  pteadj_pkg::rsp_t rsp,
	output int               fail_count,
	output int               pending,
	output int               case_seen [4]
);

	pteadj_pkg::rsp_t rebased_q[$];

	// rebase one timer item on the 64-bit date grid
	function automatic pteadj_pkg::rsp_t rebase_timer(pteadj_pkg::req_t t);
		pteadj_pkg::rsp_t r;
		logic [63:0] sh, exp_d, exd, per, diff, lag, lead, rem, stp;
		sh = t.shift_ticks;
		exp_d = t.expiry_date - sh;
		exd = t.expected_date;
		per = {1'b0, t.period_ticks};
		r.adjust_case = pteadj_pkg::CASE_SHIFT;
		if (t.is_periodic) begin
			exd = exd - sh;
			if (per == 64'd0) begin
				r.adjust_case = pteadj_pkg::CASE_ZEROPD;
			end else begin
				diff = t.time_now - exp_d;
				lag = diff - per;
				lead = diff + per;
				if (!lag[63]) begin
					rem = diff % per;
					exp_d = exp_d + diff - rem;
					r.adjust_case = pteadj_pkg::CASE_SKIP;
				end else if (sh[63] && t.has_fired && (lead == 64'd0 || lead[63])) begin
					rem = (64'd0 - diff) % per;
					stp = diff + rem;
					exp_d = exp_d + stp;
					exd = exd + stp;
					r.adjust_case = pteadj_pkg::CASE_PULL;
				end
			end
		end
		r.new_expiry = exp_d;
		r.new_expected = exd;
		return r;
	endfunction

	assign pending = rebased_q.size();

	// queue predictions and compare results
	always @(posedge clk or negedge arst_n) begin
		pteadj_pkg::rsp_t want;
		if (!arst_n) begin
			rebased_q.delete();
			fail_count <= 0;
			for (int i = 0; i < 4; i++) case_seen[i] <= 0;
		end else begin
			if (start && !busy) rebased_q.push_back(rebase_timer(req));
			if (done) begin
				if (rebased_q.size() == 0) begin
					$display("%0t: result with nothing expected: %h", $time, rsp);
					fail_count <= fail_count + 1;
				end else begin
					want = rebased_q.pop_front();
					case_seen[want.adjust_case] <= case_seen[want.adjust_case] + 1;
					if (want !== rsp) begin
						$display("%0t: expiry exp %h act %h", $time, want.new_expiry,
							rsp.new_expiry);
						$display("%0t: expected exp %h act %h", $time, want.new_expected,
							rsp.new_expected);
						$display("%0t: case exp %0d act %0d", $time, want.adjust_case,
							rsp.adjust_case);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

endmodule

### tb/sv/tb_periodic_timer_epoch_adjust.sv
// Top of the timer epoch adjust testbench: clock, reset, timer items and the
// verdict. Depends on pteadj_pkg, the block and its checker.
`timescale 1ns / 100ps

module tb_periodic_timer_epoch_adjust;

	localparam int LATENCY = 64 + 3;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic done;
	pteadj_pkg::req_t req;
	pteadj_pkg::rsp_t rsp;
	int   fail_count;
	int   pending;
	int   case_seen [4];
	int   idle_pct;
	int   sent;

	periodic_timer_epoch_adjust DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req(req), .done(done), .rsp(rsp)
	);

	periodic_timer_epoch_adjust_checker u_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .rsp(rsp), .fail_count(fail_count), .pending(pending),
		.case_seen(case_seen)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// bound the run
	initial begin
		#2000000;
		$display("periodic_timer_epoch_adjust: mismatch");
		$finish;
	end

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// pick a period: often small, sometimes wide, sometimes zero
	function automatic logic [62:0] rand_period();
		case ($urandom_range(0, 9))
			0: return '0;
			1, 2: return 63'(rand64());
			3: return 63'h7fff_ffff_ffff_ffff;
			default: return 63'($urandom_range(1, 1000));
		endcase
	endfunction

	// build a timer whose dates sit near now so every branch is reachable
	function automatic pteadj_pkg::req_t rand_timer();
		pteadj_pkg::req_t t;
		logic [63:0] base;
		t.period_ticks = rand_period();
		t.is_periodic = ($urandom_range(0, 9) != 0);
		t.has_fired = 1'($urandom_range(0, 1));
		t.time_now = rand64();
		if ($urandom_range(0, 4) == 0) begin
			t.expiry_date = rand64();
			t.expected_date = rand64();
			t.shift_ticks = rand64();
		end else begin
			base = {1'b0, t.period_ticks} * 64'($urandom_range(0, 8));
			t.shift_ticks = $urandom_range(0, 1) ? -$signed({32'd0, $urandom_range(0, 5000)})
				: $signed({32'd0, $urandom_range(0, 5000)});
			t.expiry_date = t.time_now + ($urandom_range(0, 1) ? base : -base)
				+ 64'($urandom_range(0, 2000)) - 64'd1000;
			t.expected_date = t.expiry_date - 64'($urandom_range(0, 100));
		end
		return t;
	endfunction

	// hand one item over, idling at random first
	task automatic send_timer(pteadj_pkg::req_t t);
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		req <= t;
		@(posedge clk);
		while (busy) @(posedge clk);
		sent++;
	endtask

	initial begin
		pteadj_pkg::req_t t;
		start = 1'b0;
		req = '0;
		arst_n = 1'b0;
		idle_pct = 0;
		sent = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, each case, non-periodic, zero period
		t = '0;
		send_timer(t);
		t = '1;
		send_timer(t);
		t = '0; t.is_periodic = 1'b1; t.shift_ticks = 64'sd5; t.expiry_date = 64'd100;
		t.expected_date = 64'd90;
		send_timer(t);
		t.period_ticks = 63'd10; t.time_now = 64'd200;
		send_timer(t);
		t.time_now = 64'd60; t.has_fired = 1'b1; t.shift_ticks = -64'sd40;
		send_timer(t);
		t.shift_ticks = 64'sh8000_0000_0000_0000;
		send_timer(t);
		t.shift_ticks = 64'sh7fff_ffff_ffff_ffff;
		send_timer(t);
		t.period_ticks = '1; t.time_now = '1; t.expiry_date = 64'd0;
		send_timer(t);
		t.is_periodic = 1'b0; t.expected_date = '1;
		send_timer(t);
		t = '0; t.is_periodic = 1'b1; t.has_fired = 1'b1; t.period_ticks = 63'd1;
		t.shift_ticks = -64'sd1;
		send_timer(t);
		t.period_ticks = 63'd7; t.time_now = 64'd1; t.expiry_date = 64'd30;
		t.shift_ticks = -64'sd3;
		send_timer(t);

		// random items in three idling phases
		for (int ph = 0; ph < 3; ph++) begin
			idle_pct = (ph == 0) ? 34 : (ph == 1) ? 46 : 0;
			for (int i = 0; i < 610; i++) send_timer(rand_timer());
			// hold off until every result is back
			start <= 1'b0;
			while (pending != 0) @(posedge clk);
		end

		start <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
		$display("Sent %0d timer items; cases shift %0d skip %0d pull %0d zero %0d",
			sent, case_seen[pteadj_pkg::CASE_SHIFT], case_seen[pteadj_pkg::CASE_SKIP],
			case_seen[pteadj_pkg::CASE_PULL], case_seen[pteadj_pkg::CASE_ZEROPD]);
		if (fail_count == 0) begin
			$display("periodic_timer_epoch_adjust: match");
		end else begin
			$display("periodic_timer_epoch_adjust: mismatch");
		end
		$finish;
	end

endmodule
